### rtl/dxtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_pkg
// Shared types and codes of the texture block decoder: payload structs,
// format, endian and register codes, and the decoded block descriptor.
// ----------------------------------------------------------------------------
package dxtd_pkg;

    localparam int BLOCK_W   = 64;
    localparam int TEXEL_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 2;

    // format_mode codes
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;
    localparam logic [1:0] FMT_ARGB = 2'd3;

    // endian_mode codes
    localparam logic [1:0] EM_NONE   = 2'd0;
    localparam logic [1:0] EM_8IN16  = 2'd1;
    localparam logic [1:0] EM_8IN32  = 2'd2;
    localparam logic [1:0] EM_16IN32 = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENDIAN = 2'd1;

    // alpha source of a decoded block
    localparam logic [1:0] AK_PAL = 2'd0;
    localparam logic [1:0] AK_NIB = 2'd1;
    localparam logic [1:0] AK_TAB = 2'd2;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_lo;
        logic [BLOCK_W-1:0] block_hi;
    } t_in_item;

    typedef struct packed {
        logic [TEXEL_W-1:0] texel0;
        logic [TEXEL_W-1:0] texel1;
        logic [TEXEL_W-1:0] texel2;
        logic [TEXEL_W-1:0] texel3;
        logic [1:0]         row_index;
        logic               last;
    } t_out_item;

    // decoded block, handed from the front end to the row emitter
    typedef struct packed {
        logic               is_argb;
        logic [1:0]         akind;
        logic [3:0][23:0]   pal_rgb;   // {b, g, r}
        logic [3:0][7:0]    pal_a;
        logic [31:0]        cidx;
        logic [7:0][7:0]    atab;
        logic [63:0]        abits;     // nibbles, 3-bit codes or the 8888 texel
    } t_entry;

endpackage
`default_nettype wire

### rtl/dxtd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_front
// Front end: config registers, input transfer, endian swap, endpoint
// expansion, palette and alpha table build in two register stages.
// ----------------------------------------------------------------------------
module dxtd_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dxtd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dxtd_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire dxtd_pkg::t_in_item              i_in,
    output logic                                 o_push,
    output dxtd_pkg::t_entry                     o_entry,
    input  wire logic                            i_q_full
);
    import dxtd_pkg::*;

    function automatic logic [31:0] swap32(input logic [31:0] w, input logic [1:0] m);
        logic [31:0] r;
        unique case (m)
            EM_NONE:   r = w;
            EM_8IN16:  r = {w[23:16], w[31:24], w[7:0], w[15:8]};
            EM_8IN32:  r = {w[7:0], w[15:8], w[23:16], w[31:24]};
            EM_16IN32: r = {w[15:8], w[7:0], w[31:24], w[23:16]};
            default:   r = w;
        endcase
        return r;
    endfunction

    // v*255/31 = 8v + floor(7v/31)
    function automatic logic [7:0] exp5(input logic [4:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'd1855;
        return {v, 3'b000} + {5'b0, p[15:13]};
    endfunction

    // v*255/63 = 4v + floor(v/21)
    function automatic logic [7:0] exp6(input logic [5:0] v);
        logic [1:0] q;
        if (v == 6'd63) begin
            q = 2'd3;
        end else if (v >= 6'd42) begin
            q = 2'd2;
        end else if (v >= 6'd21) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return {v, 2'b00} + {6'b0, q};
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [18:0] p;
        p = 19'(x) * 19'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd1639;
        return p[20:13];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd2341;
        return p[21:14];
    endfunction

    logic [1:0]  r_fmt;
    logic [1:0]  r_endian;

    logic        r_s1_v, n_s1_v;
    logic [63:0] r_s1_lo;
    logic [63:0] r_s1_hi;
    logic [1:0]  r_s1_fmt;

    logic        r_s2_v, n_s2_v;
    logic [1:0]  r_s2_fmt;
    logic        r_s2_four;
    logic [23:0] r_s2_e0;
    logic [23:0] r_s2_e1;
    logic [31:0] r_s2_cidx;
    logic [63:0] r_s2_lo;

    logic        accept;
    logic        s2_free;
    logic        s1_adv;

    logic [63:0] cw;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [23:0] e0;
    logic [23:0] e1;
    logic        four;

    logic [3:0][23:0] pal_rgb;
    logic [7:0][7:0]  atab;
    logic [31:0]      argb_texel;

    // handshake and stage control
    assign o_push  = r_s2_v && !i_q_full;
    assign s2_free = !r_s2_v || o_push;
    assign s1_adv  = r_s1_v && s2_free;
    assign o_ready = !r_s1_v || s2_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_s1_v = r_s1_v;
        n_s2_v = r_s2_v;
        if (accept) begin
            n_s1_v = 1'b1;
        end else if (s1_adv) begin
            n_s1_v = 1'b0;
        end
        if (s1_adv) begin
            n_s2_v = 1'b1;
        end else if (o_push) begin
            n_s2_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_DXT1;
            r_endian <= EM_NONE;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
            r_s2_v <= n_s2_v;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FORMAT: r_fmt    <= i_cfg_wdata;
                    REG_ENDIAN: r_endian <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // stage 1: swapped block
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_lo  <= {swap32(i_in.block_lo[63:32], r_endian),
                         swap32(i_in.block_lo[31:0], r_endian)};
            r_s1_hi  <= {swap32(i_in.block_hi[63:32], r_endian),
                         swap32(i_in.block_hi[31:0], r_endian)};
            r_s1_fmt <= r_fmt;
        end
    end

    // endpoint expansion
    always_comb begin
        cw   = (r_s1_fmt == FMT_DXT1) ? r_s1_lo : r_s1_hi;
        c0   = cw[15:0];
        c1   = cw[31:16];
        e0   = {exp5(c0[4:0]), exp6(c0[10:5]), exp5(c0[15:11])};
        e1   = {exp5(c1[4:0]), exp6(c1[10:5]), exp5(c1[15:11])};
        four = (c0 > c1) || (r_s1_fmt != FMT_DXT1);
    end

    // stage 2: endpoints and index bits
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_fmt  <= r_s1_fmt;
            r_s2_four <= four;
            r_s2_e0   <= e0;
            r_s2_e1   <= e1;
            r_s2_cidx <= cw[63:32];
            r_s2_lo   <= r_s1_lo;
        end
    end

    // color palette
    always_comb begin
        logic [7:0] a;
        logic [7:0] b;
        pal_rgb[0] = r_s2_e0;
        pal_rgb[1] = r_s2_e1;
        pal_rgb[2] = '0;
        pal_rgb[3] = '0;
        for (int k = 0; k < 3; k++) begin
            a = r_s2_e0[8*k +: 8];
            b = r_s2_e1[8*k +: 8];
            if (r_s2_four) begin
                pal_rgb[2][8*k +: 8] = div3({1'b0, a, 1'b0} + {2'b0, b});
                pal_rgb[3][8*k +: 8] = div3({2'b0, a} + {1'b0, b, 1'b0});
            end else begin
                pal_rgb[2][8*k +: 8] = 8'(({1'b0, a} + {1'b0, b}) >> 1);
                pal_rgb[3][8*k +: 8] = 8'd0;
            end
        end
    end

    // interpolated alpha table
    always_comb begin
        logic [7:0] a0;
        logic [7:0] a1;
        a0      = r_s2_lo[7:0];
        a1      = r_s2_lo[15:8];
        atab[0] = a0;
        atab[1] = a1;
        for (int i = 2; i < 8; i++) begin
            if (a0 > a1) begin
                atab[i] = div7(11'(8 - i) * 11'(a0) + 11'(i - 1) * 11'(a1));
            end else if (i < 6) begin
                atab[i] = div5(11'(6 - i) * 11'(a0) + 11'(i - 1) * 11'(a1));
            end else if (i == 6) begin
                atab[i] = 8'd0;
            end else begin
                atab[i] = 8'd255;
            end
        end
    end

    assign argb_texel = {r_s2_lo[31:24], r_s2_lo[7:0], r_s2_lo[15:8], r_s2_lo[23:16]};

    always_comb begin
        o_entry          = '0;
        o_entry.is_argb  = (r_s2_fmt == FMT_ARGB);
        o_entry.pal_rgb  = pal_rgb;
        o_entry.pal_a[0] = 8'd255;
        o_entry.pal_a[1] = 8'd255;
        o_entry.pal_a[2] = 8'd255;
        o_entry.pal_a[3] = r_s2_four ? 8'd255 : 8'd0;
        o_entry.cidx     = r_s2_cidx;
        o_entry.atab     = atab;
        unique case (r_s2_fmt)
            FMT_DXT1: begin
                o_entry.akind = AK_PAL;
                o_entry.abits = r_s2_lo;
            end
            FMT_DXT3: begin
                o_entry.akind = AK_NIB;
                o_entry.abits = r_s2_lo;
            end
            FMT_DXT5: begin
                o_entry.akind = AK_TAB;
                o_entry.abits = {16'b0, r_s2_lo[63:16]};
            end
            FMT_ARGB: begin
                o_entry.akind = AK_PAL;
                o_entry.abits = {32'b0, argb_texel};
            end
            default: begin
                o_entry.akind = AK_PAL;
                o_entry.abits = r_s2_lo;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/dxtd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_queue
// Small FIFO of decoded blocks between the front end and the row emitter.
// ----------------------------------------------------------------------------
module dxtd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dxtd_pkg::t_entry  i_entry,
    output logic                   o_full,
    input  wire logic              i_pop,
    output dxtd_pkg::t_entry       o_head,
    output logic                   o_empty
);
    import dxtd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

### rtl/dxtd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_back
// Row emitter: walks the head block one row per cycle unless stalled, looks
// up color and alpha for four texels (ARGB: one texel) and registers them.
// ----------------------------------------------------------------------------
module dxtd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire dxtd_pkg::t_entry  i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output dxtd_pkg::t_out_item    o_out
);
    import dxtd_pkg::*;

    logic        r_ov, n_ov;
    logic [1:0]  r_row, n_row;
    t_out_item   r_out;
    logic        load;
    logic        row_last;
    logic [3:0][31:0] tx;

    assign load     = !i_empty && (!r_ov || i_ready);
    assign row_last = i_head.is_argb || (r_row == 2'd3);
    assign o_pop    = load && row_last;
    assign o_valid  = r_ov;
    assign o_out    = r_out;

    // texel lookup for the current row
    always_comb begin
        logic [3:0] t;
        logic [1:0] sel;
        logic [5:0] aidx;
        logic [3:0] nib;
        logic [7:0] alpha;
        for (int c = 0; c < 4; c++) begin
            t    = {r_row, 2'(c)};
            sel  = i_head.cidx[{t, 1'b0} +: 2];
            aidx = {2'b00, t} + {1'b0, t, 1'b0};
            nib  = i_head.abits[{t, 2'b00} +: 4];
            unique case (i_head.akind)
                AK_PAL:  alpha = i_head.pal_a[sel];
                AK_NIB:  alpha = {nib, nib};
                AK_TAB:  alpha = i_head.atab[i_head.abits[aidx +: 3]];
                default: alpha = i_head.pal_a[sel];
            endcase
            tx[c] = {alpha, i_head.pal_rgb[sel]};
        end
    end

    always_comb begin
        n_ov  = r_ov;
        n_row = r_row;
        if (load) begin
            n_ov  = 1'b1;
            n_row = row_last ? 2'd0 : r_row + 2'd1;
        end else if (i_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_row <= 2'd0;
        end else begin
            r_ov  <= n_ov;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_head.is_argb) begin
                r_out.texel0    <= i_head.abits[31:0];
                r_out.texel1    <= '0;
                r_out.texel2    <= '0;
                r_out.texel3    <= '0;
                r_out.row_index <= 2'd0;
                r_out.last      <= 1'b1;
            end else begin
                r_out.texel0    <= tx[0];
                r_out.texel1    <= tx[1];
                r_out.texel2    <= tx[2];
                r_out.texel3    <= tx[3];
                r_out.row_index <= r_row;
                r_out.last      <= row_last;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/dxt_texture_block_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_texture_block_decoder_top
// DXT1/DXT3/DXT5 and ARGB8888 texture block decoder.
//
// Input channel (i_valid/o_ready, i_in) takes one 16-byte block per transfer.
// Output channel (o_valid/i_ready, o_out) gives one row of four RGBA8 texels
// per transfer, rows 0 to 3, last set on row 3; in ARGB8888 mode one result
// per block with last set. Config writes (i_cfg_we, i_cfg_index, i_cfg_wdata)
// take effect at once and must be made by the user while the block is idle;
// the block does not enforce this. The first row passes the stage 1 and
// stage 2 registers, the queue and the output register. Throughput: one row
// per cycle from the emitter while i_ready is high, so a block per four rows
// (one per cycle in ARGB8888 mode); the emitter sets this figure. The front
// end keeps taking blocks while rows wait, until its two stages and the
// QUEUE_DEPTH-entry block queue are full. Reset clears the config registers
// to DXT1 / no swap and empties all stages. When the receiver stalls, the
// held row stays on o_out and the front end fills up before o_ready drops.
// ----------------------------------------------------------------------------
module dxt_texture_block_decoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dxtd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dxtd_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire dxtd_pkg::t_in_item              i_in,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output dxtd_pkg::t_out_item                  o_out
);
    import dxtd_pkg::*;

    logic    push;
    logic    q_full;
    logic    q_empty;
    logic    pop;
    t_entry  push_entry;
    t_entry  head;

    dxtd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .o_push      (push),
        .o_entry     (push_entry),
        .i_q_full    (q_full)
    );

    dxtd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty)
    );

    dxtd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    // rows of one block follow each other without a gap
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_out.last) |=>
            (o_valid && o_out.row_index == $past(o_out.row_index) + 2'd1))
        else $error("row sequence broken");

    // a new block starts at row 0
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid && i_ready && o_out.last)) |-> (o_out.row_index == 2'd0))
        else $error("block does not start at row 0");

    // only row 3 of a compressed block, or a single texel, ends a block
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |-> (o_out.row_index == 2'd3 || o_out.row_index == 2'd0))
        else $error("last on a middle row");

    // the queue never takes a block while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("block queue overflow");

endmodule
`default_nettype wire

### verif/dxt_texture_block_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_texture_block_decoder_top_tb
// Self-checking bench for the texture block decoder. Blocks are pushed
// through the valid/ready input with random gaps. A local decoder works out
// every row that each block should give, and each row leaving the block is
// compared with those rows in order. Every format and every swap mode is
// used, with directed endpoint, index and alpha cases and random blocks.
// A long receiver hold fills the block up.
// ----------------------------------------------------------------------------
module dxt_texture_block_decoder_top_tb;
    import dxtd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;
    localparam int TAIL_CYCLES = 16;

    typedef logic [15:0][7:0] t_block_bytes;
    typedef logic [3:0][31:0] t_palette;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;
    logic                 i_valid;
    logic                 o_ready;
    t_in_item             i_in;
    logic                 o_valid;
    logic                 i_ready;
    t_out_item            o_out;

    t_out_item  expected_rows[$];
    logic [1:0] model_format = FMT_DXT1;
    logic [1:0] model_endian = EM_NONE;
    bit         tx_gaps = 1'b1;
    bit         rx_stalls = 1'b1;
    bit         rx_hold = 1'b0;
    int         mismatches = 0;
    int         rows_checked = 0;
    int         blocks_sent = 0;

    dxt_texture_block_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // local decoder
    // ------------------------------------------------------------------
    function automatic t_block_bytes swap_block(t_in_item it, logic [1:0] em);
        t_block_bytes raw;
        t_block_bytes sw;
        int w;
        int k;
        raw = {it.block_hi, it.block_lo};
        for (w = 0; w < 4; w++) begin
            for (k = 0; k < 4; k++) begin
                case (em)
                    EM_8IN16:  sw[4*w+k] = raw[4*w+(k^1)];
                    EM_8IN32:  sw[4*w+k] = raw[4*w+3-k];
                    EM_16IN32: sw[4*w+k] = raw[4*w+(k^2)];
                    default:   sw[4*w+k] = raw[4*w+k];
                endcase
            end
        end
        return sw;
    endfunction

    // returns {b, g, r}
    function automatic logic [23:0] expand_565(logic [15:0] c);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        r = 32'(c[15:11]) * 255 / 31;
        g = 32'(c[10:5]) * 255 / 63;
        b = 32'(c[4:0]) * 255 / 31;
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

    function automatic t_palette color_palette(logic [15:0] c0, logic [15:0] c1,
                                               bit one_bit);
        t_palette    pal;
        logic [23:0] e0;
        logic [23:0] e1;
        int unsigned a;
        int unsigned b;
        int unsigned v2;
        int unsigned v3;
        bit          four;
        int          k;
        four = (c0 > c1) || !one_bit;
        e0 = expand_565(c0);
        e1 = expand_565(c1);
        pal[0] = {8'hFF, e0};
        pal[1] = {8'hFF, e1};
        for (k = 0; k < 3; k++) begin
            a = 32'(e0[8*k +: 8]);
            b = 32'(e1[8*k +: 8]);
            if (four) begin
                v2 = (2 * a + b) / 3;
                v3 = (a + 2 * b) / 3;
            end else begin
                v2 = (a + b) / 2;
                v3 = 0;
            end
            pal[2][8*k +: 8] = v2[7:0];
            pal[3][8*k +: 8] = v3[7:0];
        end
        pal[2][31:24] = 8'hFF;
        pal[3][31:24] = four ? 8'hFF : 8'h00;
        return pal;
    endfunction

    function automatic logic [7:0][7:0] alpha_table(logic [7:0] a0, logic [7:0] a1);
        logic [7:0][7:0] tab;
        int unsigned     v;
        int unsigned     i;
        tab[0] = a0;
        tab[1] = a1;
        for (i = 2; i < 8; i++) begin
            if (a0 > a1)
                v = ((8 - i) * 32'(a0) + (i - 1) * 32'(a1)) / 7;
            else if (i < 6)
                v = ((6 - i) * 32'(a0) + (i - 1) * 32'(a1)) / 5;
            else
                v = (i == 6) ? 0 : 255;
            tab[i] = v[7:0];
        end
        return tab;
    endfunction

    function automatic void decode_block_rows(t_in_item it);
        t_block_bytes    bb;
        t_palette        pal;
        logic [7:0][7:0] atab;
        logic [47:0]     abits;
        logic [31:0]     cidx;
        logic [31:0]     tex [16];
        logic [3:0]      nib;
        t_out_item       row;
        int              i;
        int              r;
        bb = swap_block(it, model_endian);
        row = '0;
        if (model_format == FMT_ARGB) begin
            row.texel0 = {bb[3], bb[0], bb[1], bb[2]};
            row.last = 1'b1;
            expected_rows = {expected_rows, row};
            return;
        end
        if (model_format == FMT_DXT1) begin
            pal = color_palette(bb[1:0], bb[3:2], 1'b1);
            cidx = bb[7:4];
        end else begin
            pal = color_palette(bb[9:8], bb[11:10], 1'b0);
            cidx = bb[15:12];
        end
        for (i = 0; i < 16; i++)
            tex[i] = pal[cidx[2*i +: 2]];
        if (model_format == FMT_DXT5) begin
            atab = alpha_table(bb[0], bb[1]);
            abits = bb[7:2];
            for (i = 0; i < 16; i++)
                tex[i][31:24] = atab[abits[3*i +: 3]];
        end else if (model_format == FMT_DXT3) begin
            for (i = 0; i < 16; i++) begin
                nib = bb[i >> 1][4*(i & 1) +: 4];
                tex[i][31:24] = 8'(nib * 17);
            end
        end
        for (r = 0; r < 4; r++) begin
            row.texel0 = tex[4*r];
            row.texel1 = tex[4*r+1];
            row.texel2 = tex[4*r+2];
            row.texel3 = tex[4*r+3];
            row.row_index = r[1:0];
            row.last = (r == 3);
            expected_rows = {expected_rows, row};
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string what, t_out_item want, t_out_item got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %h, got %h", what, want, got);
    endfunction

    always @(posedge i_clk) begin : row_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            rows_checked++;
            if (expected_rows.size() == 0) begin
                note_mismatch("unexpected row", '0, o_out);
            end else begin
                want = expected_rows.pop_front();
                if (o_out.texel0 !== want.texel0 || o_out.texel1 !== want.texel1 ||
                    o_out.texel2 !== want.texel2 || o_out.texel3 !== want.texel3 ||
                    o_out.row_index !== want.row_index || o_out.last !== want.last)
                    note_mismatch("row mismatch", want, o_out);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver
    // ------------------------------------------------------------------
    initial begin : row_receiver
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = rx_stalls ? $urandom_range(0, 15) : 0;
            @(negedge i_clk);
            if (stall > 0 || rx_hold) begin
                i_ready <= 1'b0;
                repeat (stall > 0 ? stall : 1) @(negedge i_clk);
                while (rx_hold) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic hold_receiver(input int cycles);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sender and register writes
    // ------------------------------------------------------------------
    task automatic send_block(input t_in_item it);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!o_ready);
        decode_block_rows(it);
        blocks_sent++;
    endtask

    task automatic drain_rows();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_modes(input logic [1:0] fmt, input logic [1:0] em);
        drain_rows();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_FORMAT;
        i_cfg_wdata <= fmt;
        @(negedge i_clk);
        i_cfg_index <= REG_ENDIAN;
        i_cfg_wdata <= em;
        // spare indexes must not touch either register
        @(negedge i_clk);
        i_cfg_index <= $urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3;
        i_cfg_wdata <= CFG_DAT_W'($urandom);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_format = fmt;
        model_endian = em;
    endtask

    function automatic t_in_item random_block();
        t_in_item it;
        it.block_lo = {$urandom, $urandom};
        it.block_hi = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: it.block_lo[31:16] = it.block_lo[15:0];
            1: it.block_lo[31:8] = {3{it.block_lo[7:0]}};
            2: it.block_hi[31:16] = it.block_hi[15:0];
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_in_item make_block(logic [63:0] lo, logic [63:0] hi);
        t_in_item it;
        it.block_lo = lo;
        it.block_hi = hi;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_dxt1_modes();
        // runs on the reset register values
        send_block(make_block(64'hE4E4E4E4_0000_FFFF, {$urandom, $urandom}));
        send_block(make_block(64'hE4E4E4E4_FFFF_0000, {$urandom, $urandom}));
        send_block(make_block(64'h1B1B1B1B_7BEF_7BEF, {$urandom, $urandom}));
        send_block(make_block('0, '1));
        send_block(make_block('1, '0));
    endtask

    task automatic test_dxt3_alpha();
        apply_modes(FMT_DXT3, EM_NONE);
        send_block(make_block(64'hFEDCBA98_76543210, 64'hE4E4E4E4_F800_0001));
        send_block(make_block('0, '1));
        send_block(make_block('1, '0));
    endtask

    task automatic test_dxt5_alpha();
        apply_modes(FMT_DXT5, EM_NONE);
        send_block(make_block({48'hFAC688_FAC688, 8'h00, 8'hFF}, 64'hE4E4E4E4_0000_FFFF));
        send_block(make_block({48'hFAC688_FAC688, 8'hFF, 8'h00}, 64'h1B1B1B1B_FFFF_0000));
        send_block(make_block({48'hFAC688_FAC688, 8'h80, 8'h80}, {$urandom, $urandom}));
        send_block(make_block('1, '0));
        send_block(make_block('0, '1));
    endtask

    task automatic test_argb_texels();
        apply_modes(FMT_ARGB, EM_NONE);
        send_block(make_block({$urandom, 32'h80FF4010}, {$urandom, $urandom}));
        send_block(make_block('1, '0));
        send_block(make_block('0, '1));
    endtask

    task automatic test_endian_swaps();
        logic [1:0] em;
        for (int m = 1; m < 4; m++) begin
            em = m[1:0];
            apply_modes(FMT_ARGB, em);
            send_block(make_block({$urandom, 32'h44332211}, {$urandom, $urandom}));
            apply_modes(FMT_DXT5, em);
            send_block(make_block({48'hFAC688_FAC688, 8'h40, 8'hC0}, {$urandom, $urandom}));
        end
    endtask

    task automatic test_random_blocks();
        logic [1:0] fmt;
        logic [1:0] em;
        for (int p = 0; p < 16; p++) begin
            fmt = 2'(p % 4);
            em = 2'((p / 4 + p) % 4);
            apply_modes(fmt, em);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            repeat (6) send_block(random_block());
        end
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    task automatic test_backpressure();
        apply_modes(FMT_DXT5, EM_16IN32);
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        fork
            hold_receiver(120);
        join_none
        repeat (12) send_block(random_block());
        drain_rows();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_in = '0;
        i_ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_dxt1_modes();
        test_dxt3_alpha();
        test_dxt5_alpha();
        test_argb_texels();
        test_endian_swaps();
        test_random_blocks();
        test_backpressure();

        drain_rows();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d blocks decoded into %0d checked rows", blocks_sent, rows_checked);
        $display("all four formats under all four swap modes, plus a full-stall fill");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dxtd_pkg.sv
rtl/dxtd_front.sv
rtl/dxtd_queue.sv
rtl/dxtd_back.sv
rtl/dxt_texture_block_decoder_top.sv
verif/dxt_texture_block_decoder_top_tb.sv
